>>> rtl/assert_macros.svh
// Assertion macros included by the key list checker.
// Each macro names its assertion with a label and reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a rising clock, masked while reset is active.
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the following cycle, masked while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/lru_pkg.sv
// ---------------------------------------------------------------------------
// lru_pkg
// Sizes and types shared by the recency-ordered key list.
// ---------------------------------------------------------------------------
package lru_pkg;

	// Most keys the list can hold and the width of one stored key.
	localparam int MAX_ENTRIES = 16;
	localparam int KEY_BITS    = 32;

	// Field widths of the channels.
	localparam int FIELD_W = 32;
	localparam int OCC_W   = 5;
	localparam int CAP_W   = 5;

	// Capacity register value after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Slot index and key count widths.
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;

endpackage

>>> rtl/lru_if.sv
// ---------------------------------------------------------------------------
// lru_if
// Valid/ready channels of the key list: access, result and configuration.
// ---------------------------------------------------------------------------
interface lru_req_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [lru_pkg::FIELD_W-1:0]    access_key;

	modport source (output valid, output access_key, input ready);
	modport sink   (input valid, input access_key, output ready);
endinterface

interface lru_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  hit;
	logic                                  evicted_valid;
	logic signed [lru_pkg::FIELD_W-1:0]    evicted_key;
	logic        [lru_pkg::OCC_W-1:0]      occupancy;

	modport source (output valid, output hit, output evicted_valid, output evicted_key,
		output occupancy, input ready);
	modport sink   (input valid, input hit, input evicted_valid, input evicted_key,
		input occupancy, output ready);
endinterface

interface lru_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic        [lru_pkg::CAP_W-1:0]      capacity;

	modport source (output valid, output capacity, input ready);
	modport sink   (input valid, input capacity, output ready);
endinterface

>>> rtl/lru_cfg_reg.sv
// ---------------------------------------------------------------------------
// lru_cfg_reg
// Capacity register with the limit clamped to the range the list supports.
// ---------------------------------------------------------------------------
module lru_cfg_reg (
	input  logic             clk,
	input  logic             arst_n,
	lru_cfg_if.sink          cfg,
	output lru_pkg::cnt_t    eff_cap
);

	logic [lru_pkg::CAP_W-1:0] cap_q;

	// The register takes a write in any cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lru_pkg::CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.capacity;
		end
	end

	// Zero behaves as one; values above the list size saturate.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = lru_pkg::CNT_W'(1);
		end else if (int'(cap_q) > lru_pkg::MAX_ENTRIES) begin
			eff_cap = lru_pkg::CNT_W'(lru_pkg::MAX_ENTRIES);
		end else begin
			eff_cap = lru_pkg::CNT_W'(cap_q);
		end
	end

endmodule

>>> rtl/lru_key_list.sv
// ---------------------------------------------------------------------------
// lru_key_list
// Recency-ordered key list with hit detection and oldest-key eviction.
// ---------------------------------------------------------------------------
// Usage:
// An access beat on req carries one key. The block searches its list from the
// oldest slot upward with a single comparator, reading and then comparing one
// slot at a time, then closes the gap left by the hit or evicted key by moving
// one slot at a time, a read and then a write, through the key memory's read
// port and write port, and finally writes the key at the most recent end. One
// result beat then appears on rsp with hit, evicted_valid, evicted_key and
// occupancy. The block takes one access at a time: req.ready is high only while
// the sequencer is idle. A finished result sits in an output register, so the
// next access can be taken while the receiver stalls; if a second result is done
// before the first is taken, the sequencer holds it until rsp.ready.
// The cfg channel writes the capacity register in any cycle; it is meant to
// change only while no access is in flight.
// Reset empties the list and sets the capacity to sixteen. The key memory
// itself is not cleared, since only slots below the count are ever read.
// ---------------------------------------------------------------------------
module lru_key_list (
	input  logic     clk,
	input  logic     arst_n,
	lru_req_if.sink  req,
	lru_rsp_if.source rsp,
	lru_cfg_if.sink  cfg
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_APPEND,
		ST_DONE
	} state_t;

	state_t          state_q;
	lru_pkg::key_t   key_q;
	lru_pkg::key_t   first_q;
	lru_pkg::cnt_t   idx_q;
	lru_pkg::cnt_t   pos_q;
	lru_pkg::cnt_t   count_q;
	logic            hit_q;
	logic            evict_q;
	lru_pkg::cnt_t   eff_cap;

	// Output register of the result channel.
	logic                               rsp_valid_q;
	logic                               rsp_hit_q;
	logic                               rsp_ev_valid_q;
	logic signed [lru_pkg::FIELD_W-1:0] rsp_ev_key_q;
	logic        [lru_pkg::OCC_W-1:0]   rsp_occ_q;
	logic                               rsp_load;

	// Key memory: one read and one write port, read data registered.
	lru_pkg::key_t   mem [lru_pkg::MAX_ENTRIES];
	lru_pkg::key_t   rdata_q;
	lru_pkg::idx_t   mem_raddr;
	lru_pkg::idx_t   mem_waddr;
	lru_pkg::key_t   mem_wdata;
	logic            mem_we;

	// Helpers for the sequencer.
	lru_pkg::cnt_t   idx_next;
	lru_pkg::cnt_t   pos_next;
	lru_pkg::cnt_t   app_slot;
	logic            removed;

	lru_cfg_reg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.eff_cap (eff_cap)
	);

	assign idx_next = idx_q + lru_pkg::CNT_W'(1);
	assign pos_next = pos_q + lru_pkg::CNT_W'(1);
	assign removed  = hit_q | evict_q;

	// After a removal the list is one short, so the new key fills the last
	// occupied slot; otherwise it goes just past the end.
	assign app_slot = removed ? (count_q - lru_pkg::CNT_W'(1)) : count_q;

	// The output register takes a new result once it is empty or being drained.
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		mem_raddr = idx_q[lru_pkg::IDX_W-1:0];
		mem_waddr = pos_q[lru_pkg::IDX_W-1:0];
		mem_wdata = rdata_q;
		mem_we    = 1'b0;
		unique case (state_q)
			ST_MOVE_RD: begin
				mem_raddr = pos_next[lru_pkg::IDX_W-1:0];
			end
			ST_MOVE_WR: begin
				mem_we = 1'b1;
			end
			ST_APPEND: begin
				mem_waddr = app_slot[lru_pkg::IDX_W-1:0];
				mem_wdata = key_q;
				mem_we    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = rsp_hit_q;
	assign rsp.evicted_valid = rsp_ev_valid_q;
	assign rsp.evicted_key   = rsp_ev_key_q;
	assign rsp.occupancy     = rsp_occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			key_q          <= '0;
			first_q        <= '0;
			count_q        <= '0;
			hit_q          <= 1'b0;
			evict_q        <= 1'b0;
			idx_q          <= '0;
			pos_q          <= '0;
			rsp_valid_q    <= 1'b0;
			rsp_hit_q      <= 1'b0;
			rsp_ev_valid_q <= 1'b0;
			rsp_ev_key_q   <= '0;
			rsp_occ_q      <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						key_q   <= lru_pkg::key_t'(req.access_key);
						hit_q   <= 1'b0;
						evict_q <= 1'b0;
						idx_q   <= '0;
						// An empty list cannot hit and has nothing to evict.
						state_q <= (count_q == '0) ? ST_APPEND : ST_SRCH_RD;
					end
				end
				ST_SRCH_RD: begin
					state_q <= ST_SRCH_CMP;
				end
				ST_SRCH_CMP: begin
					// Keep the oldest key in case this access evicts it.
					if (idx_q == '0) begin
						first_q <= rdata_q;
					end
					if (rdata_q == key_q) begin
						hit_q   <= 1'b1;
						pos_q   <= idx_q;
						state_q <= ST_MOVE_RD;
					end else if (idx_next >= count_q) begin
						if (count_q >= eff_cap) begin
							evict_q <= 1'b1;
							pos_q   <= '0;
							state_q <= ST_MOVE_RD;
						end else begin
							state_q <= ST_APPEND;
						end
					end else begin
						idx_q   <= idx_next;
						state_q <= ST_SRCH_RD;
					end
				end
				ST_MOVE_RD: begin
					state_q <= (pos_next < count_q) ? ST_MOVE_WR : ST_APPEND;
				end
				ST_MOVE_WR: begin
					pos_q   <= pos_next;
					state_q <= ST_MOVE_RD;
				end
				ST_APPEND: begin
					if (!removed) begin
						count_q <= count_q + lru_pkg::CNT_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						rsp_hit_q      <= hit_q;
						rsp_ev_valid_q <= evict_q;
						rsp_ev_key_q   <= evict_q ? lru_pkg::FIELD_W'(first_q) : '0;
						rsp_occ_q      <= lru_pkg::OCC_W'(count_q);
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/lru_key_list_chk.sv
// ---------------------------------------------------------------------------
// lru_key_list_chk
// Port-level checks of the key list, attached to the key list by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_key_list_chk (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	input  logic                               req_ready,
	input  logic                               rsp_valid,
	input  logic                               rsp_ready,
	input  logic                               rsp_hit,
	input  logic                               rsp_evicted_valid,
	input  logic signed [lru_pkg::FIELD_W-1:0] rsp_evicted_key,
	input  logic        [lru_pkg::OCC_W-1:0]   rsp_occupancy
);

	// A result beat waits until the receiver takes it.
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// The block is busy in the cycle after it takes an access beat.
	`ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready)

	// A hit never evicts.
	`ASSERT_AT(a_hit_no_evict, clk, arst_n, !(rsp_valid && rsp_hit && rsp_evicted_valid))

	// Without an eviction the evicted key reads zero.
	`ASSERT_AT(a_ev_key_zero, clk, arst_n,
		!(rsp_valid && !rsp_evicted_valid && (rsp_evicted_key != '0)))

	// After any access the list holds at least one key and no more than its size.
	`ASSERT_AT(a_occ_range, clk, arst_n,
		!rsp_valid || ((rsp_occupancy != '0) && (int'(rsp_occupancy) <= lru_pkg::MAX_ENTRIES)))

endmodule

bind lru_key_list lru_key_list_chk u_lru_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_hit           (rsp.hit),
	.rsp_evicted_valid (rsp.evicted_valid),
	.rsp_evicted_key   (rsp.evicted_key),
	.rsp_occupancy     (rsp.occupancy)
);

>>> tb/tb_lru_key_list.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_lru_key_list
// Self-checking bench for the recency-ordered key list. A planned stream of
// access beats, capacity writes and drain points feeds a clocked driver. A
// shadow copy of the list predicts hit, eviction and occupancy for every
// accepted access, and a clocked monitor compares each result beat with the
// oldest prediction.
// ---------------------------------------------------------------------------
module tb_lru_key_list;

	// Percentage of cycles in which either side idles outside calm stretches.
	localparam int IDLE_PCT    = 22;
	// Cycles with no accepted beat on any channel before the run is declared hung.
	localparam int QUIET_LIMIT = 4000;
	// Cycles to watch for stray results once every prediction has been matched.
	localparam int TAIL_CYCLES = 100;
	localparam int POOL_SIZE   = 20;
	localparam int NUM_PHASES  = 13;
	localparam int PHASE_ITEMS = 150;

	// Kinds of entries in the stimulus plan. A capacity write and a drain both
	// hold the driver until every predicted result has been received.
	typedef enum logic [1:0] {
		ITEM_ACCESS,
		ITEM_CONFIG,
		ITEM_DRAIN
	} plan_kind_t;

	typedef struct {
		plan_kind_t                 kind;
		lru_pkg::key_t              key;
		logic [lru_pkg::CAP_W-1:0]  cap;
		bit                         calm;
	} plan_item_t;

	typedef struct {
		logic                       hit;
		logic                       evicted_valid;
		lru_pkg::key_t              evicted_key;
		logic [lru_pkg::OCC_W-1:0]  occupancy;
	} access_outcome_t;

	logic clk;
	// Starts high so that the nonblocking drop at time zero is a clean falling
	// edge that every reset-sensitive block sees.
	logic arst_n = 1'b1;

	lru_req_if req_ch ();
	lru_rsp_if rsp_ch ();
	lru_cfg_if cfg_ch ();

	lru_key_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Stimulus plan, filled once by the initial block and consumed by the driver.
	plan_item_t      access_plan[$];
	// Predicted results in the order the accesses were accepted.
	access_outcome_t pending_outcomes[$];

	// Shadow state of the list: slot 0 is the oldest key.
	lru_pkg::key_t             shadow_keys[lru_pkg::MAX_ENTRIES];
	int                        shadow_count;
	logic [lru_pkg::CAP_W-1:0] shadow_capacity;

	// Set by the driver when it starts an access from a calm stretch, so the
	// monitor keeps ready high through the same stretch.
	bit calm_stretch;
	int err_count;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
		err_count++;
	endtask

	// Removes one slot from the shadow list and closes the gap toward slot 0.
	task automatic drop_slot(input int pos);
		for (int i = pos; i + 1 < shadow_count; i++)
			shadow_keys[i] = shadow_keys[i + 1];
		shadow_count--;
	endtask

	// Applies one access to the shadow list and returns the result it causes.
	task automatic predict_access(input lru_pkg::key_t key, output access_outcome_t res);
		int eff_cap;
		bit found;
		eff_cap = (shadow_capacity == 0) ? 1 :
			(shadow_capacity > lru_pkg::MAX_ENTRIES) ? lru_pkg::MAX_ENTRIES :
			int'(shadow_capacity);
		found = 1'b0;
		res.evicted_valid = 1'b0;
		res.evicted_key = '0;
		// A hit takes the key out of its slot; it is put back at the recent end below.
		for (int slot = 0; slot < shadow_count && !found; slot++) begin
			if (shadow_keys[slot] == key) begin
				found = 1'b1;
				drop_slot(slot);
			end
		end
		// A miss at or above the effective capacity evicts exactly one oldest key,
		// even when the capacity was lowered below the current occupancy.
		if (!found && shadow_count >= eff_cap && shadow_count > 0) begin
			res.evicted_valid = 1'b1;
			res.evicted_key = shadow_keys[0];
			drop_slot(0);
		end
		if (shadow_count < lru_pkg::MAX_ENTRIES) begin
			shadow_keys[shadow_count] = key;
			shadow_count++;
		end
		res.hit = found;
		res.occupancy = lru_pkg::OCC_W'(shadow_count);
	endtask

	task automatic plan_access(input lru_pkg::key_t key, input bit calm);
		plan_item_t item;
		item.kind = ITEM_ACCESS;
		item.key = key;
		item.cap = '0;
		item.calm = calm;
		access_plan.push_back(item);
	endtask

	task automatic plan_capacity(input logic [lru_pkg::CAP_W-1:0] cap);
		plan_item_t item;
		item.kind = ITEM_CONFIG;
		item.key = '0;
		item.cap = cap;
		item.calm = 1'b0;
		access_plan.push_back(item);
	endtask

	task automatic plan_drain();
		plan_item_t item;
		item.kind = ITEM_DRAIN;
		item.key = '0;
		item.cap = '0;
		item.calm = 1'b0;
		access_plan.push_back(item);
	endtask

	// Driver. Each cycle it first records beats accepted at this edge: a
	// capacity write updates the shadow register, and an access beat is run
	// through the predictor. Then, if neither channel still holds a beat, it
	// takes the head of the plan. Valid lines are assigned once per edge, so
	// a beat that follows another back to back keeps valid high.
	always @(posedge clk or negedge arst_n) begin : drive_proc
		plan_item_t      head;
		access_outcome_t outcome;
		bit              send_req;
		bit              send_cfg;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.access_key <= '0;
			cfg_ch.valid <= 1'b0;
			cfg_ch.capacity <= lru_pkg::CAP_RESET;
			calm_stretch <= 1'b0;
			shadow_count = 0;
			shadow_capacity = lru_pkg::CAP_RESET;
		end else begin
			send_req = req_ch.valid && !req_ch.ready;
			send_cfg = cfg_ch.valid && !cfg_ch.ready;
			if (cfg_ch.valid && cfg_ch.ready)
				shadow_capacity = cfg_ch.capacity;
			if (req_ch.valid && req_ch.ready) begin
				predict_access(lru_pkg::key_t'(req_ch.access_key), outcome);
				pending_outcomes.push_back(outcome);
			end
			if (!send_req && !send_cfg && access_plan.size() != 0) begin
				head = access_plan[0];
				unique case (head.kind)
					ITEM_ACCESS: begin
						if (head.calm || $urandom_range(0, 99) >= IDLE_PCT) begin
							send_req = 1'b1;
							req_ch.access_key <= head.key;
							calm_stretch <= head.calm;
							void'(access_plan.pop_front());
						end
					end
					ITEM_CONFIG: begin
						// The capacity only changes once the list is idle, that is
						// once every predicted result has been received.
						if (pending_outcomes.size() == 0) begin
							send_cfg = 1'b1;
							cfg_ch.capacity <= head.cap;
							void'(access_plan.pop_front());
						end
					end
					ITEM_DRAIN: begin
						if (pending_outcomes.size() == 0)
							void'(access_plan.pop_front());
					end
					default: begin
						void'(access_plan.pop_front());
					end
				endcase
			end
			req_ch.valid <= send_req;
			cfg_ch.valid <= send_cfg;
		end
	end

	// Monitor. Every accepted result beat is matched field by field against the
	// oldest prediction; a beat with nothing outstanding is an error in itself.
	always @(posedge clk or negedge arst_n) begin : check_proc
		access_outcome_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_outcomes.size() == 0) begin
					report_mismatch("result with no outstanding access",
						{27'd0, rsp_ch.occupancy}, 32'd0);
				end else begin
					want = pending_outcomes.pop_front();
					if (rsp_ch.hit !== want.hit)
						report_mismatch("hit", {31'd0, rsp_ch.hit}, {31'd0, want.hit});
					if (rsp_ch.evicted_valid !== want.evicted_valid)
						report_mismatch("evicted_valid", {31'd0, rsp_ch.evicted_valid},
							{31'd0, want.evicted_valid});
					if (rsp_ch.evicted_key !== want.evicted_key)
						report_mismatch("evicted_key", rsp_ch.evicted_key, want.evicted_key);
					if (rsp_ch.occupancy !== want.occupancy)
						report_mismatch("occupancy", {27'd0, rsp_ch.occupancy},
							{27'd0, want.occupancy});
				end
			end
			rsp_ch.ready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Watchdog on cycles in which no channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		lru_pkg::key_t             pool[POOL_SIZE];
		logic [lru_pkg::CAP_W-1:0] phase_caps[NUM_PHASES];
		int                        eff;
		int                        span;
		bit                        calm;
		arst_n <= 1'b0;
		err_count = 0;

		// Directed part, starting from the reset capacity of sixteen. The extreme
		// keys go in first, then hits at the oldest slot, in the middle and in the
		// slot next to the most recent end.
		plan_access(32'h8000_0000, 1'b0);
		plan_access(32'h7FFF_FFFF, 1'b0);
		plan_access(32'h0000_0000, 1'b0);
		plan_access(32'hFFFF_FFFF, 1'b0);
		plan_access(32'h0000_0001, 1'b0);
		plan_access(32'h8000_0000, 1'b0);
		plan_access(32'hFFFF_FFFF, 1'b0);
		plan_access(32'h8000_0000, 1'b0);
		plan_access(32'h5555_5555, 1'b0);
		plan_access(32'hAAAA_AAAA, 1'b0);
		// Capacity lowered below the occupancy of seven: misses evict one key each
		// and leave the occupancy alone, while a hit only reorders.
		plan_capacity(lru_pkg::CAP_W'(3));
		plan_access(32'h0000_0002, 1'b0);
		plan_access(32'h0000_0000, 1'b0);
		plan_access(32'h0000_0003, 1'b0);
		// Capacity zero behaves as capacity one.
		plan_capacity(lru_pkg::CAP_W'(0));
		plan_access(32'h0000_0000, 1'b0);
		plan_access(32'h0000_0004, 1'b0);
		// The largest register value saturates to the list size, so the list
		// fills up and the last miss evicts from a full list.
		plan_capacity(lru_pkg::CAP_W'(31));
		for (int k = 10; k < 20; k++)
			plan_access(lru_pkg::key_t'(k), 1'b0);

		// Random part. Each phase sets a capacity and then mostly reuses a small
		// pool of keys, a little larger than the capacity, so that hits, moves and
		// evictions all keep happening. The rest are fresh keys.
		phase_caps = '{lru_pkg::CAP_W'(1), lru_pkg::CAP_W'(16), lru_pkg::CAP_W'(0),
			lru_pkg::CAP_W'(31), lru_pkg::CAP_W'(17), lru_pkg::CAP_W'(2),
			lru_pkg::CAP_W'(8), lru_pkg::CAP_W'(15), lru_pkg::CAP_W'(3),
			lru_pkg::CAP_W'(16), lru_pkg::CAP_W'(5), lru_pkg::CAP_W'(12),
			lru_pkg::CAP_W'(9)};
		phase_caps[NUM_PHASES - 1] = lru_pkg::CAP_W'($urandom_range(0, 31));
		for (int p = 0; p < POOL_SIZE; p++)
			pool[p] = $urandom;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			plan_capacity(phase_caps[ph]);
			eff = (phase_caps[ph] == 0) ? 1 :
				(phase_caps[ph] > lru_pkg::MAX_ENTRIES) ? lru_pkg::MAX_ENTRIES :
				int'(phase_caps[ph]);
			// About half the pool carries over, so keys left from the previous phase
			// are still hit now and then.
			for (int p = 0; p < POOL_SIZE; p++)
				if ($urandom_range(0, 1) == 1)
					pool[p] = $urandom;
			// One phase runs without any idling on either side.
			calm = (ph == 7);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				span = eff + $urandom_range(0, 3);
				if (span > POOL_SIZE)
					span = POOL_SIZE;
				if ($urandom_range(0, 99) < 75)
					plan_access(pool[$urandom_range(0, span - 1)], calm);
				else
					plan_access($urandom, calm);
				// Now and then the sender holds back until every result is in.
				if (n == PHASE_ITEMS / 2 || $urandom_range(0, 99) == 0)
					plan_drain();
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the plan to run dry and every predicted result to arrive, then
		// keep watching for a while for results that nobody asked for.
		do
			@(posedge clk);
		while (access_plan.size() != 0 || req_ch.valid || cfg_ch.valid ||
			pending_outcomes.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
